/* rtl/lipc_pkg.sv */
`timescale 1ns / 1ps

package lipc_pkg;

    localparam int unsigned PHASE_W   = 9;
    localparam int unsigned RESTORE_W = 13;
    localparam int unsigned BLINKS_W  = 3;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SET_BASE = 3'd1,
        CMD_PRESS    = 3'd2,
        CMD_CLICK    = 3'd3,
        CMD_NET_UP   = 3'd4,
        CMD_NET_DOWN = 3'd5,
        CMD_COMMISSN = 3'd6,
        CMD_UNUSED   = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        LVL_BASE       = 2'd0,
        LVL_BUTTON     = 2'd1,
        LVL_COMMISSION = 2'd2,
        LVL_NETWORK    = 2'd3
    } t_level;

    localparam logic [PHASE_W-1:0]   PRESS_ON_MS    = 9'd50;
    localparam logic [PHASE_W-1:0]   PRESS_OFF_MS   = 9'd50;
    localparam logic [PHASE_W-1:0]   CLICK_ON_MS    = 9'd60;
    localparam logic [PHASE_W-1:0]   CLICK_OFF_MS   = 9'd70;
    localparam logic [PHASE_W-1:0]   SLOW_ON_MS     = 9'd500;
    localparam logic [PHASE_W-1:0]   SLOW_OFF_MS    = 9'd500;
    localparam logic [BLINKS_W-1:0]  PRESS_TIMES    = 3'd1;
    localparam logic [BLINKS_W-1:0]  COMMISSN_TIMES = 3'd7;
    localparam logic [7:0]           CLICK_TWO      = 8'd2;
    localparam logic [7:0]           CLICK_THREE    = 8'd3;

    // restore spans: count * (on + off)
    localparam logic [RESTORE_W-1:0] PRESS_RESTORE_MS    = 13'd100;
    localparam logic [RESTORE_W-1:0] CLICK2_RESTORE_MS   = 13'd260;
    localparam logic [RESTORE_W-1:0] CLICK3_RESTORE_MS   = 13'd390;
    localparam logic [RESTORE_W-1:0] COMMISSN_RESTORE_MS = 13'd7000;

    typedef struct packed {
        logic [2:0] command;
        logic       base_level;
        logic [7:0] click_count;
    } t_item;

    typedef struct packed {
        logic       led_lit;
        logic [1:0] level;
    } t_result;

endpackage

/* rtl/lipc_core.sv */
`timescale 1ns / 1ps

module lipc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  lipc_pkg::t_item  i_item,
    output lipc_pkg::t_result o_result
);

    logic [1:0]                        r_prio, n_prio;
    logic                              r_base_on, n_base_on;
    logic [lipc_pkg::RESTORE_W-1:0]    r_restore_left, n_restore_left;
    logic                              r_restore_armed, n_restore_armed;
    logic                              r_blink_active, n_blink_active;
    logic                              r_blink_forever, n_blink_forever;
    logic                              r_phase_on, n_phase_on;
    logic [lipc_pkg::PHASE_W-1:0]      r_phase_left, n_phase_left;
    logic [lipc_pkg::BLINKS_W-1:0]     r_blinks_left, n_blinks_left;
    logic [lipc_pkg::PHASE_W-1:0]      r_on_len, n_on_len;
    logic [lipc_pkg::PHASE_W-1:0]      r_off_len, n_off_len;
    logic                              r_led, n_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio          <= lipc_pkg::LVL_BASE;
            r_base_on       <= 1'b0;
            r_restore_left  <= '0;
            r_restore_armed <= 1'b0;
            r_blink_active  <= 1'b0;
            r_blink_forever <= 1'b0;
            r_phase_on      <= 1'b0;
            r_phase_left    <= '0;
            r_blinks_left   <= '0;
            r_on_len        <= '0;
            r_off_len       <= '0;
            r_led           <= 1'b0;
        end else if (i_step) begin
            r_prio          <= n_prio;
            r_base_on       <= n_base_on;
            r_restore_left  <= n_restore_left;
            r_restore_armed <= n_restore_armed;
            r_blink_active  <= n_blink_active;
            r_blink_forever <= n_blink_forever;
            r_phase_on      <= n_phase_on;
            r_phase_left    <= n_phase_left;
            r_blinks_left   <= n_blinks_left;
            r_on_len        <= n_on_len;
            r_off_len       <= n_off_len;
            r_led           <= n_led;
        end
    end

    always_comb begin
        logic                           v_start;
        logic                           v_finite;
        logic [lipc_pkg::PHASE_W-1:0]   v_on;
        logic [lipc_pkg::PHASE_W-1:0]   v_off;
        logic [lipc_pkg::BLINKS_W-1:0]  v_times;
        logic [lipc_pkg::RESTORE_W-1:0] v_restore;
        logic [1:0]                     v_new_prio;
        logic                           v_done;

        n_prio          = r_prio;
        n_base_on       = r_base_on;
        n_restore_left  = r_restore_left;
        n_restore_armed = r_restore_armed;
        n_blink_active  = r_blink_active;
        n_blink_forever = r_blink_forever;
        n_phase_on      = r_phase_on;
        n_phase_left    = r_phase_left;
        n_blinks_left   = r_blinks_left;
        n_on_len        = r_on_len;
        n_off_len       = r_off_len;
        n_led           = r_led;

        v_start    = 1'b0;
        v_finite   = 1'b0;
        v_on       = lipc_pkg::PRESS_ON_MS;
        v_off      = lipc_pkg::PRESS_OFF_MS;
        v_times    = lipc_pkg::PRESS_TIMES;
        v_restore  = lipc_pkg::PRESS_RESTORE_MS;
        v_new_prio = lipc_pkg::LVL_BUTTON;
        v_done     = 1'b0;

        case (i_item.command)
            lipc_pkg::CMD_TICK: begin
                // blink generator first, restore timer second
                if (r_blink_active) begin
                    if (r_phase_left > lipc_pkg::PHASE_W'(1)) begin
                        n_phase_left = r_phase_left - lipc_pkg::PHASE_W'(1);
                    end else if (r_phase_on) begin
                        n_phase_on   = 1'b0;
                        n_phase_left = r_off_len;
                        n_led        = 1'b0;
                    end else begin
                        if (!r_blink_forever) begin
                            if (r_blinks_left > lipc_pkg::BLINKS_W'(1)) begin
                                n_blinks_left = r_blinks_left - lipc_pkg::BLINKS_W'(1);
                            end else begin
                                n_blinks_left  = '0;
                                n_blink_active = 1'b0;
                                n_led          = 1'b0;
                                v_done         = 1'b1;
                            end
                        end
                        if (!v_done) begin
                            n_phase_on   = 1'b1;
                            n_phase_left = r_on_len;
                            n_led        = 1'b1;
                        end
                    end
                end
                if (r_restore_armed) begin
                    if (r_restore_left > lipc_pkg::RESTORE_W'(1)) begin
                        n_restore_left = r_restore_left - lipc_pkg::RESTORE_W'(1);
                    end else begin
                        n_restore_left  = '0;
                        n_restore_armed = 1'b0;
                        if (r_prio inside {lipc_pkg::LVL_BUTTON, lipc_pkg::LVL_COMMISSION}) begin
                            n_prio          = lipc_pkg::LVL_BASE;
                            n_blink_active  = 1'b0;
                            n_blink_forever = 1'b0;
                            n_led           = r_base_on;
                        end
                    end
                end
            end
            lipc_pkg::CMD_SET_BASE: begin
                n_base_on = i_item.base_level;
                if (r_prio == lipc_pkg::LVL_BASE) begin
                    n_blink_active  = 1'b0;
                    n_blink_forever = 1'b0;
                    n_led           = i_item.base_level;
                end
            end
            lipc_pkg::CMD_PRESS: begin
                if (r_prio == lipc_pkg::LVL_BASE) begin
                    v_start  = 1'b1;
                    v_finite = 1'b1;
                end
            end
            lipc_pkg::CMD_CLICK: begin
                v_on  = lipc_pkg::CLICK_ON_MS;
                v_off = lipc_pkg::CLICK_OFF_MS;
                if (i_item.click_count == lipc_pkg::CLICK_TWO) begin
                    v_times   = 3'd2;
                    v_restore = lipc_pkg::CLICK2_RESTORE_MS;
                end else begin
                    v_times   = 3'd3;
                    v_restore = lipc_pkg::CLICK3_RESTORE_MS;
                end
                if (r_prio == lipc_pkg::LVL_BASE &&
                    (i_item.click_count == lipc_pkg::CLICK_TWO ||
                     i_item.click_count == lipc_pkg::CLICK_THREE)) begin
                    v_start  = 1'b1;
                    v_finite = 1'b1;
                end
            end
            lipc_pkg::CMD_NET_UP: begin
                if (r_prio == lipc_pkg::LVL_NETWORK) begin
                    n_restore_armed = 1'b0;
                    n_restore_left  = '0;
                    n_prio          = lipc_pkg::LVL_BASE;
                    n_blink_active  = 1'b0;
                    n_blink_forever = 1'b0;
                    n_led           = r_base_on;
                end
            end
            lipc_pkg::CMD_NET_DOWN: begin
                v_on       = lipc_pkg::SLOW_ON_MS;
                v_off      = lipc_pkg::SLOW_OFF_MS;
                v_times    = '0;
                v_new_prio = lipc_pkg::LVL_NETWORK;
                if (r_prio != lipc_pkg::LVL_NETWORK) begin
                    n_restore_armed = 1'b0;
                    n_restore_left  = '0;
                    v_start         = 1'b1;
                end
            end
            lipc_pkg::CMD_COMMISSN: begin
                v_on       = lipc_pkg::SLOW_ON_MS;
                v_off      = lipc_pkg::SLOW_OFF_MS;
                v_times    = lipc_pkg::COMMISSN_TIMES;
                v_restore  = lipc_pkg::COMMISSN_RESTORE_MS;
                v_new_prio = lipc_pkg::LVL_COMMISSION;
                if (r_prio == lipc_pkg::LVL_BASE || r_prio == lipc_pkg::LVL_BUTTON) begin
                    v_start  = 1'b1;
                    v_finite = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // every accepted blink request starts in its on phase
        if (v_start) begin
            n_prio          = v_new_prio;
            n_on_len        = v_on;
            n_off_len       = v_off;
            n_blinks_left   = v_times;
            n_blink_forever = !v_finite;
            n_blink_active  = 1'b1;
            n_phase_on      = 1'b1;
            n_phase_left    = v_on;
            n_led           = 1'b1;
            if (v_finite) begin
                n_restore_left  = v_restore;
                n_restore_armed = 1'b1;
            end
        end
    end

    assign o_result.led_lit = n_led;
    assign o_result.level   = n_prio;

endmodule

/* rtl/led_indicator_priority_controller.sv */
`timescale 1ns / 1ps

// Status LED controller with base, button, commissioning and network levels.
// Input channel: i_in_valid / o_in_stall carry one item (command, base level,
// click count). Command 0 is the 1 ms tick; the others are events.
// Output channel: o_out_valid / i_out_stall carry one result per item: the
// LED level and the priority level after that item.
// An item is taken into an input register; whenever the output register is
// empty or not stalled, the state update logic (a few compares and counter
// decrements) runs once and the result is loaded into the output register,
// raising o_out_valid; one item per cycle is sustained while not stalled.
// When the receiver stalls, the result stays in the output register and the
// input register may still take one more item; o_in_stall rises only while
// both registers are full and i_out_stall is high.
// Synchronous active-low reset empties both registers, clears the core's LED
// state, sets base priority and stops all blink and restore timers.

module led_indicator_priority_controller (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_command,
    input  logic       i_base_level,
    input  logic [7:0] i_click_count,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_led_lit,
    output logic [1:0] o_level
);

    logic              r_in_valid;
    lipc_pkg::t_item   r_item;
    logic              r_out_valid;
    lipc_pkg::t_result r_result;
    lipc_pkg::t_result w_result;
    logic              w_advance;
    logic              w_take;

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.command     <= i_command;
            r_item.base_level  <= i_base_level;
            r_item.click_count <= i_click_count;
        end
    end

    lipc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_lit   = r_result.led_lit;
    assign o_level     = r_result.level;

endmodule

/* rtl/lipc_checker.sv */
`timescale 1ns / 1ps

module lipc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_led_lit,
    input logic [1:0] o_level
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // an accepted item always yields a result unless the input side stalls behind it
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !o_in_stall |=> o_out_valid)
        else $error("accepted item produced no result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_led_lit) && $stable(o_level)))
        else $error("stalled result changed");

endmodule

bind led_indicator_priority_controller lipc_checker u_lipc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_led_lit   (o_led_lit),
    .o_level     (o_level)
);
